/* rtl/tlbmpm_pkg.sv */
// shared types and constants for the tlb multi page mapper
// no dependencies; imported by the controller, datapath and top level
package tlbmpm_pkg;

    localparam int unsigned IN_W      = 80;   // 78 payload bits padded to bytes
    localparam int unsigned OUT_W     = 120;  // 115 payload bits padded to bytes
    localparam int unsigned RES_W     = 115;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CNT_W     = 6;

    localparam logic [4:0]        MAX_PAGES  = 5'd31;
    localparam logic [ADDR_W-1:0] BASE_PAGE  = 32'h0000_1000;
    localparam logic [CNT_W-1:0]  ENTRY_CAP  = 6'd32;
    localparam logic [3:0]        MAX_MODE   = 4'd7;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_MISALIGNED = 2'd1,
        ERR_BAD_MODE   = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef enum logic [2:0] {
        K_ERROR,
        K_ODD_ONLY,
        K_PAIR,
        K_EVEN_ONLY,
        K_EMPTY
    } kind_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [IDX_W-1:0]  next_index;
        err_t              error_code;
        logic              has_entry;
        logic              odd_valid;
        logic [ADDR_W-1:0] odd_paddr;
        logic              even_valid;
        logic [ADDR_W-1:0] even_paddr;
        logic [ADDR_W-1:0] entry_vaddr;
        logic [1:0]        mask_code;
        logic [IDX_W-1:0]  entry_index;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic final_step;
    } status_t;

endpackage

/* rtl/tlbmpm_ctrl.sv */
// sequencing state machine for the tlb multi page mapper
// depends on tlbmpm_pkg; drives load and step commands to tlbmpm_dp
module tlbmpm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output tlbmpm_pkg::cmd_t    cmd,
    input  tlbmpm_pkg::status_t status
);
    import tlbmpm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.out_free && status.final_step) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no item is taken while reset is held
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            ST_RUN: begin
                cmd.step = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/tlbmpm_dp.sv */
// request registers, entry generation and output register of the mapper
// depends on tlbmpm_pkg; commanded by tlbmpm_ctrl
module tlbmpm_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tlbmpm_pkg::IN_W-1:0]   s_tdata,
    input  tlbmpm_pkg::cmd_t              cmd,
    output tlbmpm_pkg::status_t           status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tlbmpm_pkg::OUT_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import tlbmpm_pkg::*;

    // input fields
    logic [4:0]        in_start;
    logic [3:0]        in_mode;
    logic [4:0]        in_count;
    logic [ADDR_W-1:0] in_va;
    logic [ADDR_W-1:0] in_pa;

    assign in_start = s_tdata[4:0];
    assign in_mode  = s_tdata[8:5];
    assign in_count = s_tdata[13:9];
    assign in_va    = s_tdata[45:14];
    assign in_pa    = s_tdata[77:46];

    // request state
    logic [4:0]        start_reg;
    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [1:0]        mcode_reg;
    err_t              err_reg;
    logic [ADDR_W-1:0] va_reg,   va_next;
    logic [ADDR_W-1:0] pa_reg,   pa_next;
    logic [ADDR_W-1:0] size_reg;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [CNT_W-1:0]  k_reg,    k_next;
    logic              odd_first_reg;

    // setup decode
    logic [ADDR_W-1:0] size_full;
    logic [ADDR_W-1:0] size_eff;
    logic [4:0]        cnt_sat;
    logic [CNT_W-1:0]  cnt_eff;
    logic              misaligned;
    err_t              err_load;

    always_comb begin
        size_full  = BASE_PAGE << in_mode;
        misaligned = |((in_va | in_pa) & (size_full - 32'd1));
        if (misaligned) begin
            err_load = ERR_MISALIGNED;
        end else if (in_mode > MAX_MODE) begin
            err_load = ERR_BAD_MODE;
        end else begin
            err_load = ERR_NONE;
        end
        cnt_sat  = (in_count > MAX_PAGES) ? MAX_PAGES : in_count;
        // odd modes split each page in two halves
        size_eff = in_mode[0] ? (size_full >> 1) : size_full;
        cnt_eff  = in_mode[0] ? {cnt_sat, 1'b0} : {1'b0, cnt_sat};
    end

    // per-step entry generation
    kind_t   kind;
    result_t res;
    logic    last_now;

    always_comb begin
        priority if (err_reg != ERR_NONE) begin
            kind = K_ERROR;
        end else if (odd_first_reg) begin
            kind = K_ODD_ONLY;
        end else if (cnt_reg >= 6'd2 && k_reg < ENTRY_CAP) begin
            kind = K_PAIR;
        end else if (cnt_reg != 6'd0 && k_reg < ENTRY_CAP) begin
            kind = K_EVEN_ONLY;
        end else begin
            kind = K_EMPTY;
        end
    end

    always_comb begin
        res          = '0;
        res.error_code = ERR_NONE;
        idx_next     = idx_reg;
        va_next      = va_reg;
        pa_next      = pa_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        unique case (kind)
            K_ERROR: begin
                res.error_code = err_reg;
                res.next_index = {1'b0, start_reg};
            end
            K_EMPTY: begin
                res.next_index = {1'b0, start_reg};
            end
            K_ODD_ONLY: begin
                res.odd_paddr = pa_reg;
                res.odd_valid = 1'b1;
                va_next       = va_reg + size_reg;
                pa_next       = pa_reg + size_reg;
                cnt_next      = cnt_reg - 6'd1;
            end
            K_PAIR: begin
                res.even_paddr = pa_reg;
                res.even_valid = 1'b1;
                res.odd_paddr  = pa_reg + size_reg;
                res.odd_valid  = 1'b1;
                va_next        = va_reg + (size_reg << 1);
                pa_next        = pa_reg + (size_reg << 1);
                cnt_next       = cnt_reg - 6'd2;
            end
            K_EVEN_ONLY: begin
                res.even_paddr = pa_reg;
                res.even_valid = 1'b1;
                cnt_next       = cnt_reg - 6'd1;
            end
            default: begin
                res.next_index = {1'b0, start_reg};
            end
        endcase
        if (kind == K_ODD_ONLY || kind == K_PAIR || kind == K_EVEN_ONLY) begin
            res.entry_index = idx_reg;
            res.mask_code   = mcode_reg;
            res.entry_vaddr = va_reg;
            res.has_entry   = 1'b1;
            res.next_index  = idx_reg + 6'd1;
            idx_next        = idx_reg + 6'd1;
            k_next          = k_reg + 6'd1;
            last_now        = !(cnt_next != 6'd0 && k_next < ENTRY_CAP);
        end else begin
            last_now        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg     <= in_start;
            idx_reg       <= {1'b0, in_start};
            mcode_reg     <= in_mode[2:1];
            err_reg       <= err_load;
            va_reg        <= in_va;
            pa_reg        <= in_pa;
            size_reg      <= size_eff;
            cnt_reg       <= cnt_eff;
            k_reg         <= '0;
            odd_first_reg <= (|(in_va & size_eff)) && (cnt_eff != 6'd0);
        end else if (cmd.step) begin
            idx_reg       <= idx_next;
            va_reg        <= va_next;
            pa_reg        <= pa_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            odd_first_reg <= 1'b0;
        end
    end

    // output register
    result_t out_res_reg;
    logic    out_last_reg;
    logic    out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_res_reg  <= res;
            out_last_reg <= last_now;
        end
    end

    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.final_step = last_now;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_res_reg};
    assign m_tlast  = out_last_reg;

    a_k_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (k_reg <= ENTRY_CAP))
        else $error("entry counter past its cap");

    a_error_is_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.error_code != ERR_NONE) |-> out_last_reg)
        else $error("error result not marked last");

    a_non_entry_is_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.has_entry) |-> out_last_reg)
        else $error("non-entry result not marked last");

    a_next_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.has_entry) |->
            (out_res_reg.next_index == out_res_reg.entry_index + 6'd1))
        else $error("next index does not follow entry index");

endmodule

/* rtl/tlb_multi_page_mapper_unit.sv */
// tlb multi page mapper: one request in, a run of even/odd tlb entries out
// depends on tlbmpm_pkg, tlbmpm_ctrl and tlbmpm_dp
// first result: registered by the first step after the load
// throughput: a request giving n results (1 to 32) holds the input until its
//   final result is stepped out: a setup step on load, then one result per
//   cycle from the step logic into the output register unless it is stalled
// reset: aresetn (synchronous, active low) returns the sequencer to idle,
//   holds the input not ready and empties the output register; request and
//   payload registers keep old data
module tlb_multi_page_mapper_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_index[4:0], size_sel[8:5], page_count[13:9],
    // virt_base[45:14], phys_base[77:46], zero pad above
    input  logic [tlbmpm_pkg::IN_W-1:0]   s_tdata,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_index[5:0], mask_code[7:6], entry_vaddr[39:8], even_paddr[71:40],
    // even_valid[72], odd_paddr[104:73], odd_valid[105], has_entry[106],
    // error_code[108:107], next_index[114:109], zero pad above
    output logic [tlbmpm_pkg::OUT_W-1:0]  m_tdata,
    output logic                          m_tlast     // last result of a request
);
    import tlbmpm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: takes a request when idle, then steps until the final result
    tlbmpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: alignment and mode checks on load, one result per step,
    // output register parting the step logic from the result channel
    tlbmpm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/tlb_multi_page_mapper_unit_tb.sv */
// self-checking testbench for tlb_multi_page_mapper_unit: requests go in on the stream input,
// each result is checked against a behavioural predictor of the tlb entry runs
// depends on tlbmpm_pkg and the rtl of tlb_multi_page_mapper_unit
module tlb_multi_page_mapper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbmpm_pkg::*;

    // one mapping request as the sender sees it
    typedef struct {
        logic [4:0]  start_index;
        logic [3:0]  size_sel;
        logic [4:0]  page_count;
        logic [31:0] virt_base;
        logic [31:0] phys_base;
    } map_req_t;

    // one predicted tlb write plus its end-of-request flag
    typedef struct {
        result_t res;
        logic    last;
    } tlb_write_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    tlb_write_t tlb_writes_q[$];   // predicted results still to arrive, oldest first
    int         mismatches    = 0;
    bit         src_gaps_on   = 1'b1;
    bit         sink_stalls_on = 1'b1;
    int         sink_hold     = 0;
    result_t    seen_res;
    tlb_write_t want_write;

    tlb_multi_page_mapper_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop, well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // idle length for one item on either side
    function automatic int draw_wait(bit enabled);
        return enabled ? int'($urandom_range(0, 18)) : 0;
    endfunction

    function automatic map_req_t make_req(logic [4:0] idx, logic [3:0] mode, logic [4:0] cnt,
                                          logic [31:0] va, logic [31:0] pa);
        map_req_t r;
        r.start_index = idx;
        r.size_sel    = mode;
        r.page_count  = cnt;
        r.virt_base   = va;
        r.phys_base   = pa;
        return r;
    endfunction

    // random address aligned to the full page size of a mode
    function automatic logic [31:0] aligned_addr(logic [3:0] mode);
        return $urandom & ~((BASE_PAGE << mode) - 32'd1);
    endfunction

    // result that writes no entry: error or nothing to map
    function automatic tlb_write_t status_write(err_t err, logic [5:0] idx);
        tlb_write_t w;
        w.res            = '0;
        w.res.error_code = err;
        w.res.next_index = idx;
        w.last           = 1'b0;
        return w;
    endfunction

    function automatic tlb_write_t entry_write(logic [5:0] idx, logic [1:0] mask,
                                               logic [31:0] va, logic [31:0] ep, logic ev,
                                               logic [31:0] op, logic ov);
        tlb_write_t w;
        w.res             = '0;
        w.res.entry_index = idx;
        w.res.mask_code   = mask;
        w.res.entry_vaddr = va;
        w.res.even_paddr  = ev ? ep : 32'd0;
        w.res.even_valid  = ev;
        w.res.odd_paddr   = ov ? op : 32'd0;
        w.res.odd_valid   = ov;
        w.res.has_entry   = 1'b1;
        w.res.error_code  = ERR_NONE;
        w.res.next_index  = idx + 6'd1;
        w.last            = 1'b0;
        return w;
    endfunction

    // works out the whole run of tlb writes for one request and queues it
    function automatic void predict_mapping(map_req_t r);
        tlb_write_t  run[$];
        logic [31:0] span;
        logic [31:0] va;
        logic [31:0] pa;
        logic [6:0]  pages;
        logic [5:0]  idx;
        logic [1:0]  mask;
        span  = BASE_PAGE << r.size_sel;
        va    = r.virt_base;
        pa    = r.phys_base;
        idx   = {1'b0, r.start_index};
        pages = (r.page_count > MAX_PAGES) ? {2'b0, MAX_PAGES} : {2'b0, r.page_count};
        // alignment is judged before the mode, for every mode
        if (((va | pa) & (span - 32'd1)) != 32'd0) begin
            run.push_back(status_write(ERR_MISALIGNED, idx));
        end else if (r.size_sel > MAX_MODE) begin
            run.push_back(status_write(ERR_BAD_MODE, idx));
        end else begin
            mask = r.size_sel[2:1];
            // odd modes: half-size pages, twice as many
            if (r.size_sel[0]) begin
                span  = span >> 1;
                pages = pages << 1;
            end
            // start in an odd page: lone odd half first
            if ((va & span) != 32'd0 && pages != 7'd0) begin
                run.push_back(entry_write(idx, mask, va, 32'd0, 1'b0, pa, 1'b1));
                idx   = idx + 6'd1;
                va    = va + span;
                pa    = pa + span;
                pages = pages - 7'd1;
            end
            while (pages >= 7'd2 && run.size() < int'(ENTRY_CAP)) begin
                run.push_back(entry_write(idx, mask, va, pa, 1'b1, pa + span, 1'b1));
                idx   = idx + 6'd1;
                va    = va + (span << 1);
                pa    = pa + (span << 1);
                pages = pages - 7'd2;
            end
            // one page left over: even half only
            if (pages != 7'd0 && run.size() < int'(ENTRY_CAP)) begin
                run.push_back(entry_write(idx, mask, va, pa, 1'b1, 32'd0, 1'b0));
            end
            if (run.size() == 0) begin
                run.push_back(status_write(ERR_NONE, idx));
            end
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[i]) begin
            tlb_writes_q.push_back(run[i]);
        end
    endfunction

    // mostly well-formed requests, the rest bad modes and misaligned noise
    function automatic map_req_t random_request();
        map_req_t    r;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        r.start_index = 5'($urandom_range(0, 31));
        r.page_count  = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 31));
        if (pick < 70) begin
            r.size_sel  = 4'($urandom_range(0, MAX_MODE));
            r.virt_base = aligned_addr(r.size_sel);
            r.phys_base = aligned_addr(r.size_sel);
        end else if (pick < 82) begin
            r.size_sel  = 4'($urandom_range(MAX_MODE + 1, 15));
            r.virt_base = aligned_addr(r.size_sel);
            r.phys_base = aligned_addr(r.size_sel);
        end else begin
            r.size_sel  = 4'($urandom_range(0, 15));
            r.virt_base = $urandom;
            r.phys_base = (pick < 91) ? aligned_addr(r.size_sel) : $urandom;
        end
        return r;
    endfunction

    // called on a rising edge; returns on the edge where the item is taken
    task automatic send_request(map_req_t r);
        int gap;
        gap = draw_wait(src_gaps_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, r.phys_base, r.virt_base, r.page_count, r.size_sel,
                     r.start_index};
        do @(posedge aclk); while (!s_tready);
        predict_mapping(r);
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // result side: draws a stall for every item it takes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold = 0;
        end else if (m_tready && m_tvalid) begin
            sink_hold = draw_wait(sink_stalls_on);
            m_tready <= (sink_hold == 0);
        end else if (!m_tready) begin
            if (sink_hold <= 1) begin
                m_tready <= 1'b1;
            end
            sink_hold = sink_hold - 1;
        end
    end

    // every taken result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res = result_t'(m_tdata[RES_W-1:0]);
            if (tlb_writes_q.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing, got %0h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want_write = tlb_writes_q.pop_front();
                check_field("entry_index", 32'(want_write.res.entry_index),
                            32'(seen_res.entry_index));
                check_field("mask_code", 32'(want_write.res.mask_code),
                            32'(seen_res.mask_code));
                check_field("entry_vaddr", want_write.res.entry_vaddr, seen_res.entry_vaddr);
                check_field("even_paddr",  want_write.res.even_paddr,  seen_res.even_paddr);
                check_field("even_valid", 32'(want_write.res.even_valid),
                            32'(seen_res.even_valid));
                check_field("odd_paddr",   want_write.res.odd_paddr,   seen_res.odd_paddr);
                check_field("odd_valid", 32'(want_write.res.odd_valid),
                            32'(seen_res.odd_valid));
                check_field("has_entry", 32'(want_write.res.has_entry),
                            32'(seen_res.has_entry));
                check_field("error_code", 32'(want_write.res.error_code),
                            32'(seen_res.error_code));
                check_field("next_index", 32'(want_write.res.next_index),
                            32'(seen_res.next_index));
                check_field("last_result", 32'(want_write.last), 32'(m_tlast));
            end
        end
    end

    task automatic run_random_requests(int count);
        repeat (count) send_request(random_request());
    endtask

    // field extremes, both error kinds, empty runs and the odd/even shapes
    task automatic test_corner_cases();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        send_request(make_req(5'd0, 4'd0, 5'd0, 32'h0, 32'h0));                     // all zero
        send_request(make_req(5'd31, 4'd15, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));  // all ones
        send_request(make_req(5'd3, 4'd0, 5'd4, 32'h0000_1234, 32'h0));             // va off
        send_request(make_req(5'd4, 4'd3, 5'd4, 32'h0, 32'h0000_4000));             // pa off
        send_request(make_req(5'd7, 4'd8, 5'd5, 32'h0010_0000, 32'h0020_0000));     // bad mode
        send_request(make_req(5'd9, 4'd15, 5'd2, 32'hF800_0000, 32'h0800_0000));    // top mode
        // misalignment wins over a bad mode
        send_request(make_req(5'd10, 4'd15, 5'd2, 32'h0000_1000, 32'h0));
        // zero count from an odd page maps nothing
        send_request(make_req(5'd11, 4'd0, 5'd0, 32'h0000_1000, 32'h0));
        send_request(make_req(5'd12, 4'd2, 5'd1, 32'h0000_4000, 32'h0100_0000));    // odd only
        send_request(make_req(5'd13, 4'd2, 5'd1, 32'h0000_8000, 32'h0200_0000));    // even only
        send_request(make_req(5'd14, 4'd4, 5'd2, 32'h0001_0000, 32'h0300_0000));    // odd, even
        // full page counts, the first two wrapping past the top of the address space
        send_request(make_req(5'd31, 4'd7, 5'd31, 32'hFFF8_0000, 32'hFFF8_0000));
        send_request(make_req(5'd31, 4'd6, 5'd31, 32'hFFFC_0000, 32'h0FFC_0000));
        send_request(make_req(5'd0, 4'd1, 5'd31, 32'h0, 32'h0));
        for (int m = 0; m <= int'(MAX_MODE); m++) begin
            send_request(make_req(5'(m * 4), 4'(m), 5'd3, aligned_addr(4'(m)),
                                  aligned_addr(4'(m))));
        end
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        run_random_requests(60);
    endtask

    task automatic test_random_idling();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        run_random_requests(118);
    endtask

    // stalls on one side only, then the other
    task automatic test_one_sided_stalls();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b1;
        run_random_requests(20);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b0;
        run_random_requests(20);
    endtask

    // sender holds off until every predicted result has come out, for 20 requests, then sends freely
    task automatic test_drained_requests();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (tlb_writes_q.size() != 0) @(posedge aclk);
            send_request(random_request());
        end
        run_random_requests(20);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_cases();
        test_back_to_back();
        test_random_idling();
        test_one_sided_stalls();
        test_drained_requests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tlb_writes_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && tlb_writes_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
